// File: rtl/core/binary_to_balanced_ternary_core_macros.svh
// Assertion macros used by the checker file of the ternary converter.
`ifndef BINARY_TO_BALANCED_TERNARY_CORE_MACROS_SVH
`define BINARY_TO_BALANCED_TERNARY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbt assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define BBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbt assertion failed: next-cycle implication");

`endif

// File: rtl/core/bbt_pkg.sv
// Package with the shared constants, types and helpers of the ternary converter.
`timescale 1ns / 1ps

package bbt_pkg;

   localparam int DEF_IN_WIDTH  = 32;
   localparam int DEF_MAX_TRITS = 21;

   // Number of magnitude bits the divider consumes per cycle while it runs.
   localparam int CHUNK_BITS = 8;

   localparam logic [1:0] SYM_ZERO  = 2'd0;
   localparam logic [1:0] SYM_PLUS  = 2'd1;
   localparam logic [1:0] SYM_MINUS = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CARRY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic run;
   } div_ctrl_type;

   typedef struct packed {
      logic       done;
      logic [1:0] digit;
      logic       quot_nonzero;
   } div_stat_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [1:0] symbol;
   } stack_ctrl_type;

   // Long division by three over one chunk, most significant bit first.
   // Returns the new remainder above the quotient bits of the chunk.
   function automatic logic [CHUNK_BITS+1:0] div3_chunk(
      input logic [1:0]            rem_in,
      input logic [CHUNK_BITS-1:0] bits
   );
      logic [1:0]            rem;
      logic [2:0]            part;
      logic [CHUNK_BITS-1:0] quot;
      rem = rem_in;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         part = {rem, bits[i]};
         if (part >= 3'd3) begin
            quot[i] = 1'b1;
            part    = part - 3'd3;
         end else begin
            quot[i] = 1'b0;
         end
         rem = part[1:0];
      end
      return {rem, quot};
   endfunction

   // Swaps plus and minus when the input was negative.
   function automatic logic [1:0] orient_symbol(input logic [1:0] sym, input logic negative);
      logic [1:0] result;
      result = sym;
      if (negative) begin
         if (sym == SYM_PLUS) begin
            result = SYM_MINUS;
         end else if (sym == SYM_MINUS) begin
            result = SYM_PLUS;
         end
      end
      return result;
   endfunction

endpackage

// File: rtl/core/bbt_if.sv
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps

interface bbt_req_if
   import bbt_pkg::*;
#(
   parameter int IN_WIDTH = DEF_IN_WIDTH
) ();
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] signed_value;

   modport source (output valid, output signed_value, input ready);
   modport sink   (input valid, input signed_value, output ready);
endinterface

interface bbt_rsp_if
   import bbt_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [1:0] trit_symbol;
   logic       last_trit;

   modport source (output valid, output trit_symbol, output last_trit, input ready);
   modport sink   (input valid, input trit_symbol, input last_trit, output ready);
endinterface

// File: rtl/core/bbt_div3_serial.sv
// Chunk-serial divide-by-three unit that produces one ternary digit per pass.
`timescale 1ns / 1ps

module bbt_div3_serial
   import bbt_pkg::*;
#(
   parameter int IN_WIDTH = DEF_IN_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  div_ctrl_type        ctrl,
   input  logic [IN_WIDTH-1:0] magnitude,
   output div_stat_type        stat
);

   localparam int CHUNKS     = (IN_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int PAD_WIDTH  = CHUNKS * CHUNK_BITS;
   localparam int CNT_W      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int LAST_CHUNK = CHUNKS - 1;

   logic [PAD_WIDTH-1:0]  value_ff, value_in;
   logic [1:0]            rem_ff, rem_in;
   logic [CNT_W-1:0]      chunk_ff, chunk_in;
   logic                  nz_ff, nz_in;

   logic [CHUNK_BITS+1:0] step_res;
   logic [CHUNK_BITS-1:0] quot_bits;
   logic [1:0]            rem_next;
   logic [PAD_WIDTH-1:0]  value_shifted;
   logic                  last_chunk;

   assign step_res   = div3_chunk(rem_ff, value_ff[PAD_WIDTH-1 -: CHUNK_BITS]);
   assign quot_bits  = step_res[CHUNK_BITS-1:0];
   assign rem_next   = step_res[CHUNK_BITS+1:CHUNK_BITS];
   assign last_chunk = (chunk_ff == CNT_W'(LAST_CHUNK));

   // The quotient enters at the bottom while the dividend leaves at the top.
   generate
      if (PAD_WIDTH == CHUNK_BITS) begin : g_single
         assign value_shifted = quot_bits;
      end else begin : g_multi
         assign value_shifted = {value_ff[PAD_WIDTH-CHUNK_BITS-1:0], quot_bits};
      end
   endgenerate

   assign stat.done         = ctrl.run && last_chunk;
   assign stat.digit        = rem_next;
   assign stat.quot_nonzero = nz_ff | (|quot_bits);

   always_comb begin
      value_in = value_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      nz_in    = nz_ff;
      if (ctrl.load) begin
         value_in = PAD_WIDTH'(magnitude);
         rem_in   = 2'd0;
         chunk_in = '0;
         nz_in    = 1'b0;
      end else if (ctrl.run) begin
         value_in = value_shifted;
         if (last_chunk) begin
            rem_in   = 2'd0;
            chunk_in = '0;
            nz_in    = 1'b0;
         end else begin
            rem_in   = rem_next;
            chunk_in = chunk_ff + CNT_W'(1);
            nz_in    = stat.quot_nonzero;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= 2'd0;
         chunk_ff <= '0;
         nz_ff    <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         chunk_ff <= chunk_in;
         nz_ff    <= nz_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: rtl/core/bbt_trit_stack.sv
// Shift-register stack that holds the trits of one conversion.
`timescale 1ns / 1ps

module bbt_trit_stack
   import bbt_pkg::*;
#(
   parameter int MAX_TRITS = DEF_MAX_TRITS
) (
   input  logic           clock,
   input  stack_ctrl_type ctrl,
   output logic [1:0]     top_symbol
);

   logic [1:0] stack_ff [MAX_TRITS];
   logic [1:0] stack_in [MAX_TRITS];

   // Pushes move every entry one place down; pops move them back up.
   always_comb begin
      for (int i = 0; i < MAX_TRITS; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (ctrl.push) begin
         stack_in[0] = ctrl.symbol;
         for (int i = 1; i < MAX_TRITS; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (ctrl.pop) begin
         for (int i = 0; i < MAX_TRITS - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TRITS; i++) begin
         stack_ff[i] <= stack_in[i];
      end
   end

   assign top_symbol = stack_ff[0];

endmodule

// File: rtl/core/binary_to_balanced_ternary_core.sv
// Top level of the binary to balanced ternary converter.
// Each request word carries one signed integer; the block answers with its
// balanced ternary trits, most significant first, one response word per trit,
// and sets last_trit on the least significant one. Zero gives a single zero
// trit, and there are never leading zero trits. The magnitude is divided by
// three in a chunk-serial unit that consumes CHUNK_BITS (8) bits per cycle;
// zero needs no division. A carry left after the last digit adds a leading
// plus trit (minus for a negative value). The trits then leave from a shift
// stack at one per cycle while the response side is ready. A new request
// word is taken only once the last trit of the previous one has been loaded
// into the response register; that register lets the next conversion start
// while the last trit still waits. Values that would need more than MAX_TRITS
// trits keep only the least significant MAX_TRITS of them.
`timescale 1ns / 1ps

module binary_to_balanced_ternary_core
   import bbt_pkg::*;
#(
   parameter int IN_WIDTH  = DEF_IN_WIDTH,
   parameter int MAX_TRITS = DEF_MAX_TRITS
) (
   input  logic     clock,
   input  logic     reset,
   bbt_req_if.sink  req_bus,
   bbt_rsp_if.source rsp_bus
);

   localparam int COUNT_W = $clog2(MAX_TRITS + 1);

   // Control state.
   state_type          state_ff, state_in;
   logic               negative_ff, negative_in;
   logic               carry_ff, carry_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_symbol_ff, rsp_symbol_in;
   logic               rsp_last_ff, rsp_last_in;

   // Datapath signals.
   logic [IN_WIDTH-1:0] raw_value;
   logic                raw_negative;
   logic [IN_WIDTH-1:0] magnitude;
   logic                mag_zero;
   logic                accept;
   logic                out_free;
   logic                emit_load;
   logic [1:0]          digit_sum;
   logic [1:0]          digit_symbol;
   logic                carry_next;
   logic [COUNT_W-1:0]  count_plus;
   logic                room;
   logic [1:0]          top_symbol;

   div_ctrl_type   div_ctrl;
   div_stat_type   div_stat;
   stack_ctrl_type stack_ctrl;

   // The magnitude of the most negative value wraps to itself, which is the
   // correct unsigned magnitude.
   assign raw_value    = req_bus.signed_value;
   assign raw_negative = raw_value[IN_WIDTH-1];
   assign magnitude    = raw_negative ? IN_WIDTH'(~raw_value + IN_WIDTH'(1)) : raw_value;
   assign mag_zero     = (magnitude == '0);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign count_plus = count_ff + COUNT_W'(1);
   assign room       = (count_plus < COUNT_W'(MAX_TRITS));

   // An ordinary ternary digit plus the pending carry becomes one balanced
   // trit; a sum of two or three passes a carry on to the next trit.
   assign digit_sum = div_stat.digit + {1'b0, carry_ff};

   always_comb begin
      case (digit_sum)
         2'd0: begin
            digit_symbol = SYM_ZERO;
            carry_next   = 1'b0;
         end
         2'd1: begin
            digit_symbol = SYM_PLUS;
            carry_next   = 1'b0;
         end
         2'd2: begin
            digit_symbol = SYM_MINUS;
            carry_next   = 1'b1;
         end
         default: begin
            digit_symbol = SYM_ZERO;
            carry_next   = 1'b1;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = mag_zero ? ST_EMIT : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               if (!room) begin
                  state_in = ST_EMIT;
               end else if (div_stat.quot_nonzero) begin
                  state_in = ST_DIVIDE;
               end else if (carry_next) begin
                  state_in = ST_CARRY;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CARRY: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && (count_ff == COUNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      negative_in       = negative_ff;
      carry_in          = carry_ff;
      count_in          = count_ff;
      div_ctrl          = '0;
      stack_ctrl        = '0;
      stack_ctrl.symbol = SYM_ZERO;
      emit_load         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               negative_in = raw_negative;
               carry_in    = 1'b0;
               if (mag_zero) begin
                  stack_ctrl.push   = 1'b1;
                  stack_ctrl.symbol = SYM_ZERO;
                  count_in          = COUNT_W'(1);
               end else begin
                  div_ctrl.load = 1'b1;
                  count_in      = '0;
               end
            end
         end
         ST_DIVIDE: begin
            div_ctrl.run = 1'b1;
            if (div_stat.done) begin
               stack_ctrl.push   = 1'b1;
               stack_ctrl.symbol = orient_symbol(digit_symbol, negative_ff);
               carry_in          = carry_next;
               count_in          = count_plus;
            end
         end
         ST_CARRY: begin
            stack_ctrl.push   = 1'b1;
            stack_ctrl.symbol = orient_symbol(SYM_PLUS, negative_ff);
            carry_in          = 1'b0;
            count_in          = count_plus;
         end
         ST_EMIT: begin
            if (out_free) begin
               stack_ctrl.pop = 1'b1;
               emit_load      = 1'b1;
               count_in       = count_ff - COUNT_W'(1);
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   // The response register takes the top of the stack whenever it is free in the emit state.
   always_comb begin
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (emit_load) begin
         rsp_symbol_in = top_symbol;
         rsp_last_in   = (count_ff == COUNT_W'(1));
         rsp_valid_in  = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         negative_ff  <= 1'b0;
         carry_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         negative_ff  <= negative_in;
         carry_ff     <= carry_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.trit_symbol = rsp_symbol_ff;
   assign rsp_bus.last_trit   = rsp_last_ff;

   bbt_div3_serial #(
      .IN_WIDTH (IN_WIDTH)
   ) u_div3 (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .magnitude (magnitude),
      .stat      (div_stat)
   );

   bbt_trit_stack #(
      .MAX_TRITS (MAX_TRITS)
   ) u_stack (
      .clock      (clock),
      .ctrl       (stack_ctrl),
      .top_symbol (top_symbol)
   );

endmodule

// File: rtl/core/bbt_checker.sv
// Port-level checker for the ternary converter, bound to the top level.
`timescale 1ns / 1ps
`include "binary_to_balanced_ternary_core_macros.svh"

module bbt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_trit_symbol,
   input logic       rsp_last_trit
);

   // A stalled response word keeps its contents.
   `BBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_trit_symbol) && $stable(rsp_last_trit))

   // Only the three defined trit codes are ever shown.
   `BBT_ASSERT_NOW(a_symbol_code, clock, reset, rsp_valid, rsp_trit_symbol != 2'd3)

   // Once a request word is taken, the block is busy with it in the next cycle.
   `BBT_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // While a run is still being emitted, no new request is taken.
   `BBT_ASSERT_NOW(a_busy_in_run, clock, reset, rsp_valid && !rsp_last_trit, !req_ready)

   // A request is taken beside a waiting response word only if that word ends its run.
   `BBT_ASSERT_NOW(a_ready_idle, clock, reset, req_valid && req_ready && rsp_valid, rsp_last_trit)

endmodule

bind binary_to_balanced_ternary_core bbt_checker u_bbt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_trit_symbol (rsp_bus.trit_symbol),
   .rsp_last_trit   (rsp_bus.last_trit)
);

// File: sim/binary_to_balanced_ternary_core_tb.sv
// Self-checking testbench for the binary to balanced ternary converter core.
`timescale 1ns / 1ps

module binary_to_balanced_ternary_core_tb;
   import bbt_pkg::*;

   localparam int IN_WIDTH       = DEF_IN_WIDTH;
   localparam int MAX_TRITS      = DEF_MAX_TRITS;
   localparam int RANDOM_WORDS   = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int HOLD_OFF_AT    = 120;
   localparam int HOLD_OFF_LEN   = 300;

   // One response word as the converter should produce it.
   typedef struct packed {
      logic [1:0] symbol;
      logic       last;
   } trit_word_type;

   logic clock;
   logic reset;

   bbt_req_if #(.IN_WIDTH(IN_WIDTH)) req_bus ();
   bbt_rsp_if                        rsp_bus ();

   binary_to_balanced_ternary_core #(
      .IN_WIDTH (IN_WIDTH),
      .MAX_TRITS(MAX_TRITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic signed [IN_WIDTH-1:0] pending_values[$];
   trit_word_type              pending_trits[$];
   int                         mismatch_count = 0;
   int                         words_sent     = 0;
   int                         total_words    = 0;
   int                         trits_checked  = 0;
   bit                         idling_on      = 1'b1;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input int wanted, input int seen);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, wanted, seen);
      mismatch_count++;
   endtask

   // Appends one value to the list of words still to be sent.
   function automatic void queue_value(input logic signed [IN_WIDTH-1:0] value);
      pending_values = {pending_values, value};
   endfunction

   // Converts one value to balanced ternary and queues its trits, most
   // significant first, with the end mark on the least significant one.
   function automatic void predict_trits(input logic signed [IN_WIDTH-1:0] value);
      longint        magnitude;
      logic          negative;
      logic [1:0]    digits[$];
      logic [1:0]    sym;
      longint        remainder;
      trit_word_type word;
      negative  = value[IN_WIDTH-1];
      magnitude = negative ? -longint'(value) : longint'(value);
      if (magnitude == 0) begin
         digits = {digits, SYM_ZERO};
      end
      while (magnitude != 0 && digits.size() < MAX_TRITS) begin
         remainder = magnitude % 3;
         magnitude = magnitude / 3;
         if (remainder == 2) begin
            sym = negative ? SYM_PLUS : SYM_MINUS;
            magnitude++;
         end else if (remainder == 1) begin
            sym = negative ? SYM_MINUS : SYM_PLUS;
         end else begin
            sym = SYM_ZERO;
         end
         digits = {digits, sym};
      end
      for (int k = digits.size() - 1; k >= 0; k--) begin
         word.symbol = digits[k];
         word.last   = (k == 0);
         pending_trits = {pending_trits, word};
      end
   endfunction

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (!idling_on) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 94) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(15, 50);
   endfunction

   // Small values, magnitudes of random bit length and full random words, so that
   // short and long trit runs both occur often.
   function automatic logic signed [IN_WIDTH-1:0] random_value();
      int                 roll;
      int                 bits;
      logic [IN_WIDTH-1:0] raw;
      roll = $urandom_range(0, 9);
      if (roll < 3) begin
         return $signed($urandom_range(0, 80)) - 40;
      end else if (roll < 7) begin
         bits = $urandom_range(1, IN_WIDTH - 1);
         raw  = $urandom & ((32'd1 << bits) - 1);
         return $urandom_range(0, 1) ? -$signed(raw) : $signed(raw);
      end
      raw = $urandom;
      return $signed(raw);
   endfunction

   // Request driver: a new word is put up once the previous one has gone.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_trits(req_bus.signed_value);
            words_sent++;
            if (words_sent % 40 == 0) begin
               idling_on = ($urandom_range(0, 3) != 0);
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_values.size() != 0) begin
               req_bus.signed_value <= pending_values.pop_front();
               req_bus.valid        <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with its own ready pattern and one long hold-off that
   // backs the block up into its request side.
   int recv_gap    = 0;
   int hold_cycles = 0;
   bit hold_done   = 1'b0;
   always @(posedge clock) begin
      trit_word_type wanted;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_trits.size() == 0) begin
               report_mismatch("unexpected trit word", -1, rsp_bus.trit_symbol);
            end else begin
               wanted = pending_trits.pop_front();
               if (rsp_bus.trit_symbol !== wanted.symbol) begin
                  report_mismatch("trit_symbol", wanted.symbol, rsp_bus.trit_symbol);
               end
               if (rsp_bus.last_trit !== wanted.last) begin
                  report_mismatch("last_trit", wanted.last, rsp_bus.last_trit);
               end
            end
            trits_checked++;
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && trits_checked >= HOLD_OFF_AT) begin
            hold_done   = 1'b1;
            hold_cycles = HOLD_OFF_LEN;
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            recv_gap = pick_gap();
         end
      end
   end

   // Ends the run when neither channel has moved a word for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.signed_value = '0;
      rsp_bus.ready        = 1'b0;

      // Directed words: zero, small values of both signs, carry chains that
      // add a leading trit, the longest runs, both range ends and the most
      // negative integer.
      queue_value(0);
      queue_value(1);
      queue_value(-1);
      queue_value(2);
      queue_value(-2);
      queue_value(3);
      queue_value(-3);
      queue_value(4);
      queue_value(13);
      queue_value(14);
      queue_value(-14);
      queue_value(1162261467);
      queue_value(-1162261467);
      queue_value(1743392200);
      queue_value(1743392201);
      queue_value(-1743392201);
      queue_value(32'sh5555_5555);
      queue_value(-32'sh5555_5555);
      queue_value(32'sh7FFF_FFFF);
      queue_value(-32'sh7FFF_FFFF);
      queue_value(32'sh8000_0000);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         queue_value(random_value());
      end
      total_words = pending_values.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every word must have been taken and every predicted trit seen.
      wait (words_sent == total_words && pending_trits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_trits.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: binary_to_balanced_ternary_core.f
+incdir+rtl/core
rtl/core/bbt_pkg.sv
rtl/core/bbt_if.sv
rtl/core/bbt_div3_serial.sv
rtl/core/bbt_trit_stack.sv
rtl/core/binary_to_balanced_ternary_core.sv
rtl/core/bbt_checker.sv
sim/binary_to_balanced_ternary_core_tb.sv
